@@ rtl/core/bfiq_pkg.sv @@
// Shared types and constants for the Bloom filter insert and query block.
`default_nettype none

package bfiq_pkg;

  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int STEP_W     = $clog2(HASH_W + 1);

  localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

  localparam logic [SIZE_W-1:0] FILTER_BYTES_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HASH  = 4'd1;

  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic              step;
    logic              clear;
    logic [BYTE_W-1:0] key_byte;
  } hash_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/bloom_filter_insert_query.sv @@
// Top level of the Bloom filter: control sequencer, configuration and bit store.
//
// Usage. Key bytes enter one per item on start/busy: an item is taken at a
// clock edge with start high and busy low. in_last_byte marks the final byte
// and in_req_type on that byte selects add (0) or check (1).
// Bytes that are not the last leave busy low.
// After the final byte busy stays high while each hash in use (the second
// only when enabled) goes through a load step, the bit-serial remainder
// unit, then a read and, on an add, a read-modify-write of the bit store.
// The result is shown for one cycle with out_valid, in the cycle busy
// falls, and the next key byte may be given in that same cycle.
// The receiver cannot stall; results are never held.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. After reset a clearing pass zeroes the bit
// store, one byte per cycle, with busy high; config writes are taken then.
`default_nettype none

module bloom_filter_insert_query #(
  parameter int FILTER_BYTES = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_req_type,
  input  wire logic [bfiq_pkg::BYTE_W-1:0]     in_key_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  output logic                                 out_key_present,
  output logic                                 out_was_check,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bfiq_pkg::*;

  localparam int NB = $clog2(FILTER_BYTES + 1);
  localparam int DW = NB + 3;
  localparam int AW = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(FILTER_BYTES - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOAD   = 6'b000100,
    S_MOD    = 6'b001000,
    S_READ   = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]     clr_r, clr_nxt;
  logic              sel_r, sel_nxt;
  logic              hit_r, hit_nxt;
  logic              check_r, check_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              present_r, present_nxt;
  logic              was_check_r, was_check_nxt;
  logic [SIZE_W-1:0] filter_bytes_r;
  logic              hash2_en_r;

  logic              accept;
  hash_ctl_t         hash_ctl;
  logic              hash_clear;
  logic [HASH_W-1:0] word_sum;
  logic [HASH_W-1:0] fnv_value;

  logic [NB-1:0]     bytes_used;
  logic [DW-1:0]     divisor;
  logic              mod_start;
  logic              mod_busy;
  logic [DW-1:0]     mod_rem;

  logic [AW-1:0]     byte_addr;
  logic [2:0]        bit_sel;
  logic [BYTE_W-1:0] bit_mask;
  logic              bit_hit;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bytes_r <= FILTER_BYTES_RST;
      hash2_en_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_BYTES: filter_bytes_r <= cfg_data[SIZE_W-1:0];
        CFG_SECOND_HASH:  hash2_en_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Size in use, held between one byte and the full store.
  always_comb begin
    if (filter_bytes_r == '0) begin
      bytes_used = NB'(1);
    end else if (32'(filter_bytes_r) > 32'(FILTER_BYTES)) begin
      bytes_used = NB'(FILTER_BYTES);
    end else begin
      bytes_used = NB'(filter_bytes_r);
    end
  end

  assign divisor = {bytes_used, 3'b000};

  assign hash_ctl.step     = accept;
  assign hash_ctl.clear    = hash_clear;
  assign hash_ctl.key_byte = in_key_byte;

  bfiq_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (hash_ctl),
    .sum_o (word_sum),
    .fnv_o (fnv_value)
  );

  bfiq_mod #(
    .DW (DW)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (mod_start),
    .dividend_i (sel_r ? fnv_value : word_sum),
    .divisor_i  (divisor),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  assign byte_addr = mod_rem[AW+2:3];
  assign bit_sel   = mod_rem[2:0];
  assign bit_mask  = BYTE_W'(1) << bit_sel;
  assign bit_hit   = mem_rdata[bit_sel];

  bfiq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FILTER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (byte_addr),
    .rdata (mem_rdata)
  );

  // The two bit accesses of a key are strictly sequenced: the second read
  // is issued long after the first write, so no forwarding is needed.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    sel_nxt       = sel_r;
    hit_nxt       = hit_r;
    check_nxt     = check_r;
    out_valid_nxt = 1'b0;
    present_nxt   = present_r;
    was_check_nxt = was_check_r;
    mod_start     = 1'b0;
    hash_clear    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = byte_addr;
    mem_wdata     = mem_rdata | bit_mask;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept && in_last_byte) begin
          check_nxt = in_req_type;
          hit_nxt   = 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        mod_start = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (!mod_busy) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        hit_nxt = hit_r & bit_hit;
        mem_we  = !check_r;
        if (!sel_r && hash2_en_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          out_valid_nxt = 1'b1;
          present_nxt   = check_r ? (hit_r & bit_hit) : 1'b1;
          was_check_nxt = check_r;
          hash_clear    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r       <= sel_nxt;
    hit_r       <= hit_nxt;
    check_r     <= check_nxt;
    present_r   <= present_nxt;
    was_check_r <= was_check_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_key_present = present_r;
  assign out_was_check   = was_check_r;

endmodule

`default_nettype wire

@@ rtl/core/bfiq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module bfiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/bfiq_hash.sv @@
// Running word-sum and FNV-1a hashes over the bytes of one key.
`default_nettype none

module bfiq_hash (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bfiq_pkg::hash_ctl_t            ctl_i,
  output logic      [bfiq_pkg::HASH_W-1:0]    sum_o,
  output logic      [bfiq_pkg::HASH_W-1:0]    fnv_o
);

  import bfiq_pkg::*;

  logic [HASH_W-1:0] sum_r, sum_nxt;
  logic [HASH_W-1:0] gather_r, gather_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [HASH_W-1:0] fnv_r, fnv_nxt;
  logic [HASH_W-1:0] byte_ext;
  logic [HASH_W-1:0] gather_add;
  logic [HASH_W-1:0] fnv_prod;

  assign byte_ext   = {{(HASH_W-BYTE_W){1'b0}}, ctl_i.key_byte};
  assign gather_add = gather_r | (byte_ext << {phase_r, 3'b000});
  // Only the low word of the product is kept, as in a 32-bit wrapping multiply.
  assign fnv_prod   = (fnv_r ^ byte_ext) * FNV_PRIME;

  always_comb begin
    sum_nxt    = sum_r;
    gather_nxt = gather_r;
    phase_nxt  = phase_r;
    fnv_nxt    = fnv_r;
    if (ctl_i.clear) begin
      sum_nxt    = '0;
      gather_nxt = '0;
      phase_nxt  = '0;
      fnv_nxt    = FNV_OFFSET;
    end else if (ctl_i.step) begin
      phase_nxt = phase_r + 2'd1;
      fnv_nxt   = fnv_prod;
      if (phase_r == PHASE_LAST) begin
        sum_nxt    = sum_r + gather_add;
        gather_nxt = '0;
      end else begin
        gather_nxt = gather_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      gather_r <= '0;
      phase_r  <= '0;
      fnv_r    <= FNV_OFFSET;
    end else begin
      sum_r    <= sum_nxt;
      gather_r <= gather_nxt;
      phase_r  <= phase_nxt;
      fnv_r    <= fnv_nxt;
    end
  end

  assign sum_o = sum_r;
  assign fnv_o = fnv_r;

endmodule

`default_nettype wire

@@ rtl/core/bfiq_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module bfiq_mod #(
  parameter int DW = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_i,
  input  wire logic [bfiq_pkg::HASH_W-1:0] dividend_i,
  input  wire logic [DW-1:0]               divisor_i,
  output logic                             busy_o,
  output logic      [DW-1:0]               rem_o
);

  import bfiq_pkg::*;

  logic [HASH_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DW:0]       trial;
  logic [DW:0]       div_ext;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one conditional subtract suffices.
  assign trial   = {rem_r, quo_r[HASH_W-1]};
  assign div_ext = {1'b0, div_r};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (start_i) begin
      quo_nxt = dividend_i;
      rem_nxt = '0;
      div_nxt = divisor_i;
      cnt_nxt = STEP_W'(HASH_W);
    end else if (cnt_r != '0) begin
      quo_nxt = quo_r << 1;
      rem_nxt = (trial >= div_ext) ? DW'(trial - div_ext) : trial[DW-1:0];
      cnt_nxt = cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy_o = (cnt_r != '0);
  assign rem_o  = rem_r;

endmodule

`default_nettype wire

@@ rtl/core/bfiq_checker.sv @@
// Port-level assertions for the Bloom filter, bound to its top level.
`default_nettype none

module bfiq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last_byte,
  input wire logic out_valid,
  input wire logic out_key_present,
  input wire logic out_was_check
);

  // Reset always starts the clearing pass and drops any pending result.
  a_reset_busy : assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("busy low or result shown after reset");

  // A final byte always starts the bit store accesses.
  a_last_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |=> busy)
    else $error("final byte did not start the lookup");

  // An add always reports the key as present.
  a_add_present : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_check |-> out_key_present)
    else $error("add reported key absent");

  // A result only follows a busy period and never repeats in the next cycle.
  a_result_once : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy ##1 !out_valid)
    else $error("result not tied to the end of a lookup");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

`default_nettype wire

@@ tb/bfiq_result_checker.sv @@
// Checker that predicts the Bloom filter's add and check results and compares them.
`default_nettype none

module bfiq_result_checker #(
  parameter int FILTER_BYTES = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic                            in_req_type,
  input  wire logic [bfiq_pkg::BYTE_W-1:0]     in_key_byte,
  input  wire logic                            in_last_byte,
  input  wire logic                            out_valid,
  input  wire logic                            out_key_present,
  input  wire logic                            out_was_check,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] OFFSET_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_MULT     = 32'd16777619;

  typedef struct packed {
    logic key_present;
    logic was_check;
  } verdict_t;

  logic [7:0]                    filter_mem [FILTER_BYTES];
  logic [31:0]                   sum_acc;
  logic [31:0]                   gather_acc;
  logic [31:0]                   fnv_acc;
  logic [1:0]                    lane;
  logic [bfiq_pkg::SIZE_W-1:0]   size_reg;
  logic                          fnv_on;
  verdict_t                      verdict_q[$];
  int                            errors = 0;

  function automatic void clear_hash();
    sum_acc    = '0;
    gather_acc = '0;
    lane       = '0;
    fnv_acc    = OFFSET_BASIS;
  endfunction

  // A size of zero counts as one byte and sizes above the store are clipped.
  function automatic logic [31:0] active_bits();
    logic [31:0] n;
    n = 32'(size_reg);
    if (n == 0) n = 1;
    if (n > FILTER_BYTES) n = FILTER_BYTES;
    return n * 8;
  endfunction

  function automatic logic probe_bit(logic [31:0] hash, logic adding);
    logic [31:0] pos;
    logic        was;
    pos = hash % active_bits();
    was = filter_mem[pos >> 3][pos[2:0]];
    if (adding) filter_mem[pos >> 3][pos[2:0]] = 1'b1;
    return was;
  endfunction

  function automatic void absorb_byte(logic [7:0] b, logic last, logic is_check);
    verdict_t v;
    logic     hit;
    gather_acc = gather_acc | (32'(b) << (8 * lane));
    if (lane == bfiq_pkg::PHASE_LAST) begin
      sum_acc    = sum_acc + gather_acc;
      gather_acc = '0;
    end
    lane    = lane + 2'd1;
    fnv_acc = (fnv_acc ^ 32'(b)) * FNV_MULT;
    if (last) begin
      hit = probe_bit(sum_acc, !is_check);
      // With the second hash on, both bits are touched on an add, so the second probe must run even after a miss.
      if (fnv_on) hit = probe_bit(fnv_acc, !is_check) & hit;
      v.key_present = is_check ? hit : 1'b1;
      v.was_check   = is_check;
      verdict_q = {verdict_q, v};
      clear_hash();
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      foreach (filter_mem[i]) filter_mem[i] = '0;
      clear_hash();
      size_reg = bfiq_pkg::FILTER_BYTES_RST;
      fnv_on   = 1'b1;
      verdict_q.delete();
    end else begin
      // The result leaving at this edge is older than any item taken at it.
      if (out_valid === 1'b1) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected: key_present %b was_check %b",
                   $time, out_key_present, out_was_check);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_key_present !== want.key_present) begin
            $display("%0t: key_present expected %b, actual %b",
                     $time, want.key_present, out_key_present);
            errors++;
          end
          if (out_was_check !== want.was_check) begin
            $display("%0t: was_check expected %b, actual %b",
                     $time, want.was_check, out_was_check);
            errors++;
          end
        end
      end
      if (start && !busy) absorb_byte(in_key_byte, in_last_byte, in_req_type);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfiq_pkg::CFG_FILTER_BYTES: size_reg = cfg_data[bfiq_pkg::SIZE_W-1:0];
          bfiq_pkg::CFG_SECOND_HASH:  fnv_on = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count    <= errors;
    awaited_count <= verdict_q.size();
  end

endmodule

`default_nettype wire

@@ tb/bloom_filter_insert_query_tb.sv @@
// Testbench top for the Bloom filter: drives keys and register writes and gives the verdict.
`default_nettype none

module bloom_filter_insert_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   FILTER_BYTES  = 1024;
  localparam logic REQ_ADD       = 1'b0;
  localparam logic REQ_CHECK     = 1'b1;
  localparam int   RUN_LIMIT     = 400000;
  localparam int   SETTLE_CYCLES = 100;
  localparam int   MAX_KEY       = 16;
  localparam int   POOL_DEPTH    = 32;
  localparam int   PHASE_ITEMS   = 125;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic                            in_req_type;
  logic [bfiq_pkg::BYTE_W-1:0]     in_key_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_key_present;
  logic                            out_was_check;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data;

  int         fail_count;
  int         awaited_count;
  int         cycle_count = 0;
  int         gap_limit;
  int         bytes_sent = 0;
  logic [7:0] key_buf [MAX_KEY];
  int         key_len;
  logic [7:0] pool_bytes [POOL_DEPTH][MAX_KEY];
  int         pool_len [POOL_DEPTH];
  int         pool_fill = 0;
  int         pool_next = 0;

  bloom_filter_insert_query #(
    .FILTER_BYTES(FILTER_BYTES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key_byte     (in_key_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_key_present (out_key_present),
    .out_was_check   (out_was_check),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  bfiq_result_checker #(
    .FILTER_BYTES(FILTER_BYTES)
  ) presence_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key_byte     (in_key_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_key_present (out_key_present),
    .out_was_check   (out_was_check),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Start is left high after acceptance so that back-to-back items need no second assignment.
  task automatic send_byte(logic req, logic [7:0] b, logic last);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= req;
    in_key_byte  <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    bytes_sent++;
  endtask

  // The request kind on bytes before the last is random, since only the last one counts.
  task automatic send_key(logic req);
    for (int i = 0; i < key_len; i++) begin
      send_byte((i == key_len - 1) ? req : 1'($urandom_range(0, 1)), key_buf[i],
                i == key_len - 1);
    end
    if (req == REQ_ADD) begin
      for (int i = 0; i < key_len; i++) pool_bytes[pool_next][i] = key_buf[i];
      pool_len[pool_next] = key_len;
      pool_next = (pool_next + 1) % POOL_DEPTH;
      if (pool_fill < POOL_DEPTH) pool_fill++;
    end
  endtask

  // The first key byte sits in the lowest byte of the vector.
  task automatic load_key(int len, logic [39:0] bytes);
    key_len = len;
    for (int i = 0; i < len; i++) key_buf[i] = bytes[8*i +: 8];
  endtask

  task automatic make_random_key();
    key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_KEY) : $urandom_range(1, 8);
    for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom);
  endtask

  task automatic recall_key();
    int slot;
    slot    = $urandom_range(0, pool_fill - 1);
    key_len = pool_len[slot];
    for (int i = 0; i < key_len; i++) key_buf[i] = pool_bytes[slot][i];
  endtask

  task automatic cfg_beat(logic [bfiq_pkg::CFG_IDX_W-1:0] idx,
                          logic [bfiq_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // A write to an unused index goes last, so a wrong decode would spoil the live settings.
  task automatic program_filter(logic [bfiq_pkg::CFG_DATA_W-1:0] size_val, logic hash_on,
                                logic poke_unused);
    cfg_beat(bfiq_pkg::CFG_FILTER_BYTES, size_val);
    cfg_beat(bfiq_pkg::CFG_SECOND_HASH,
             (bfiq_pkg::CFG_DATA_W'($urandom) & ~bfiq_pkg::CFG_DATA_W'(1))
             | bfiq_pkg::CFG_DATA_W'(hash_on));
    if (poke_unused) begin
      cfg_beat(bfiq_pkg::CFG_IDX_W'(bfiq_pkg::CFG_SECOND_HASH + $urandom_range(1, 14)),
               bfiq_pkg::CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                              target;
    int                              pick;
    logic [bfiq_pkg::CFG_DATA_W-1:0] size_val;
    logic                            hash_on;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_req_type  <= REQ_ADD;
    in_key_byte  <= '0;
    in_last_byte <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    gap_limit    = 8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Byte extremes, a full word of ones, keys shorter than a word and two absent keys.
    load_key(1, 40'h00);
    send_key(REQ_ADD);
    send_key(REQ_CHECK);
    load_key(4, 40'hFF_FF_FF_FF);
    send_key(REQ_ADD);
    send_key(REQ_CHECK);
    load_key(4, 40'h04_03_02_01);
    send_key(REQ_CHECK);
    load_key(1, 40'hFF);
    send_key(REQ_CHECK);
    load_key(5, 40'hAA_FE_01_7F_80);
    send_key(REQ_ADD);
    send_key(REQ_CHECK);
    wait_drain();

    // The store is never cleared between phases, so each size change is seen on old contents.
    for (int p = 0; p < 8; p++) begin
      hash_on = 1'($urandom_range(0, 1));
      case (p)
        0: begin size_val = '0;           hash_on = 1'b1; end
        1: begin size_val = '1;           hash_on = 1'b0; end
        2: begin size_val = 1;            hash_on = 1'b0; end
        3: begin size_val = bfiq_pkg::CFG_DATA_W'(FILTER_BYTES); hash_on = 1'b1; end
        4: begin size_val = 2;            hash_on = 1'b1; end
        default: begin
          size_val = ($urandom_range(0, 1) == 0) ? bfiq_pkg::CFG_DATA_W'($urandom_range(1, 24))
                                                 : bfiq_pkg::CFG_DATA_W'($urandom);
        end
      endcase
      program_filter(size_val, hash_on, p == 0 || $urandom_range(0, 1) == 1);
      gap_limit = (p % 3 == 1) ? 0 : 8;
      target    = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 || pool_fill == 0) begin
          make_random_key();
          send_key(REQ_ADD);
        end else if (pick < 80) begin
          recall_key();
          send_key(REQ_CHECK);
        end else begin
          make_random_key();
          send_key(REQ_CHECK);
        end
      end
      wait_drain();
    end

    if (fail_count == 0 && awaited_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/bfiq_pkg.sv
rtl/core/bfiq_ram.sv
rtl/core/bfiq_hash.sv
rtl/core/bfiq_mod.sv
rtl/core/bloom_filter_insert_query.sv
rtl/core/bfiq_checker.sv
tb/bfiq_result_checker.sv
tb/bloom_filter_insert_query_tb.sv
